// ----- rtl/core/pfb_pkg.sv -----
// Shared types and constants of the packed frame buffer refresh core.
`timescale 1ns / 1ps
`default_nettype none
package pfb_pkg;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned COLOR_W    = 16;
  localparam int unsigned GROUP_W    = 6;
  localparam int unsigned PIXGRP_W   = 64;
  localparam int unsigned PAL_DEPTH  = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned MAX_LANES  = 4;

  localparam int unsigned WIDTH_DEF  = 240;
  localparam int unsigned HEIGHT_DEF = 240;
  localparam int unsigned PPR_DEF    = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_PIXEL = 3'd0,
    CMD_GET_PIXEL = 3'd1,
    CMD_FILL      = 3'd2,
    CMD_CLEAR     = 3'd3,
    CMD_PAL_WRITE = 3'd4,
    CMD_REFRESH   = 3'd5
  } cmd_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SP_RD,
    ST_SP_WR,
    ST_GP_RD,
    ST_GP_DAT,
    ST_FILL,
    ST_PAL,
    ST_RF_DRD,
    ST_RF_DCHK,
    ST_RF_FB,
    ST_RF_PAL,
    ST_RF_ACC,
    ST_RF_PUSH,
    ST_PUSH
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/core/pfb_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module pfb_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [AddrW-1:0]  raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/core/pfb_seq.sv -----
// Command sequencer with read-modify-write, sweep and refresh control and the result register.
`timescale 1ns / 1ps
`default_nettype none
module pfb_seq #(
  parameter int unsigned WIDTH             = pfb_pkg::WIDTH_DEF,
  parameter int unsigned HEIGHT            = pfb_pkg::HEIGHT_DEF,
  parameter int unsigned PIXELS_PER_RESULT = pfb_pkg::PPR_DEF,
  localparam int unsigned StoreBytes = (WIDTH * HEIGHT + 1) / 2,
  localparam int unsigned FbAw       = (StoreBytes > 1) ? $clog2(StoreBytes) : 1,
  localparam int unsigned RowAw      = (HEIGHT > 1) ? $clog2(HEIGHT) : 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [pfb_pkg::CMD_W-1:0]         command_i,
  input  wire logic [pfb_pkg::COORD_W-1:0]       x_coord_i,
  input  wire logic [pfb_pkg::COORD_W-1:0]       y_coord_i,
  input  wire logic [pfb_pkg::IDX_W-1:0]         colour_index_i,
  input  wire logic [pfb_pkg::IDX_W-1:0]         palette_slot_i,
  input  wire logic [pfb_pkg::COLOR_W-1:0]       palette_colour_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [pfb_pkg::IDX_W-1:0]         pixel_value_o,
  output logic                                   row_sent_o,
  output logic      [pfb_pkg::COORD_W-1:0]       row_number_o,
  output logic      [pfb_pkg::GROUP_W-1:0]       group_index_o,
  output logic      [pfb_pkg::PIXGRP_W-1:0]      pixel_group_o,
  output logic                                   last_o,
  output logic                                   fb_we_o,
  output logic      [FbAw-1:0]                   fb_waddr_o,
  output logic      [pfb_pkg::BYTE_W-1:0]        fb_wdata_o,
  output logic      [FbAw-1:0]                   fb_raddr_o,
  input  wire logic [pfb_pkg::BYTE_W-1:0]        fb_rdata_i,
  output logic                                   dirty_we_o,
  output logic      [RowAw-1:0]                  dirty_waddr_o,
  output logic                                   dirty_wdata_o,
  output logic      [RowAw-1:0]                  dirty_raddr_o,
  input  wire logic                              dirty_rdata_i,
  output logic                                   pal_we_o,
  output logic      [pfb_pkg::IDX_W-1:0]         pal_waddr_o,
  output logic      [pfb_pkg::COLOR_W-1:0]       pal_wdata_o,
  output logic      [pfb_pkg::IDX_W-1:0]         pal_raddr_o,
  input  wire logic [pfb_pkg::COLOR_W-1:0]       pal_rdata_i
);

  import pfb_pkg::*;

  localparam int unsigned LinW    = $clog2(WIDTH * HEIGHT);
  localparam int unsigned Groups  = (WIDTH + PIXELS_PER_RESULT - 1) / PIXELS_PER_RESULT;
  localparam int unsigned GcW     = (Groups > 1) ? $clog2(Groups) : 1;
  localparam int unsigned KW      = $clog2(PIXELS_PER_RESULT + 1);
  localparam int unsigned PxW     = $clog2(WIDTH + PIXELS_PER_RESULT);
  localparam int unsigned InitLen = (HEIGHT > PAL_DEPTH) ? HEIGHT : PAL_DEPTH;
  localparam int unsigned SweepMx = (StoreBytes > InitLen) ? StoreBytes : InitLen;
  localparam int unsigned SwW     = $clog2(SweepMx + 1);

  state_e state_q, state_d;

  logic [COORD_W-1:0]  y_q, y_d;
  logic [LinW-1:0]     lin_q, lin_d;
  logic [IDX_W-1:0]    ci_q, ci_d;
  logic [BYTE_W-1:0]   fill_byte_q, fill_byte_d;
  logic [IDX_W-1:0]    pal_slot_q, pal_slot_d;
  logic [COLOR_W-1:0]  pal_col_q, pal_col_d;
  logic [COORD_W-1:0]  res_row_q, res_row_d;
  logic [IDX_W-1:0]    pv_q, pv_d;
  logic [SwW-1:0]      sw_q, sw_d;
  logic [GcW-1:0]      g_q, g_d;
  logic [KW-1:0]       k_q, k_d;
  logic [PxW-1:0]      px_q, px_d;
  logic                px_ok_q, px_ok_d;
  logic [PIXGRP_W-1:0] pix_q, pix_d;

  logic                out_valid_q, out_valid_d;
  logic [IDX_W-1:0]    out_pv_q, out_pv_d;
  logic                out_sent_q, out_sent_d;
  logic [COORD_W-1:0]  out_row_q, out_row_d;
  logic [GROUP_W-1:0]  out_grp_q, out_grp_d;
  logic [PIXGRP_W-1:0] out_pix_q, out_pix_d;
  logic                out_last_q, out_last_d;

  logic accept, can_push, in_range, y_ok;
  logic fill_done, pal_done, init_done, k_last, g_last;
  logic load_plain, load_group;
  logic [IDX_W-1:0] nibble;
  cmd_e cmd;

  assign cmd        = cmd_e'(command_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign can_push   = !out_valid_q || !out_stall_i;
  assign y_ok       = {1'b0, y_coord_i} < (COORD_W + 1)'(HEIGHT);
  assign in_range   = y_ok && ({1'b0, x_coord_i} < (COORD_W + 1)'(WIDTH));
  assign fill_done  = (sw_q == SwW'(StoreBytes - 1));
  assign pal_done   = (sw_q == SwW'(HEIGHT - 1));
  assign init_done  = (sw_q == SwW'(InitLen - 1));
  assign k_last     = (k_q == KW'(PIXELS_PER_RESULT - 1));
  assign g_last     = (g_q == GcW'(Groups - 1));
  assign nibble     = lin_q[0] ? fb_rdata_i[7:4] : fb_rdata_i[3:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (init_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (cmd)
            CMD_SET_PIXEL: state_d = in_range ? ST_SP_RD : ST_PUSH;
            CMD_GET_PIXEL: state_d = in_range ? ST_GP_RD : ST_PUSH;
            CMD_FILL:      state_d = ST_FILL;
            CMD_CLEAR:     state_d = ST_FILL;
            CMD_PAL_WRITE: state_d = ST_PAL;
            CMD_REFRESH:   state_d = y_ok ? ST_RF_DRD : ST_PUSH;
            default:       state_d = ST_PUSH;
          endcase
        end
      end
      ST_SP_RD:   state_d = ST_SP_WR;
      ST_SP_WR:   state_d = ST_PUSH;
      ST_GP_RD:   state_d = ST_GP_DAT;
      ST_GP_DAT:  state_d = ST_PUSH;
      ST_FILL: begin
        if (fill_done) state_d = ST_PUSH;
      end
      ST_PAL: begin
        if (pal_done) state_d = ST_PUSH;
      end
      ST_RF_DRD:  state_d = ST_RF_DCHK;
      ST_RF_DCHK: state_d = dirty_rdata_i ? ST_RF_FB : ST_PUSH;
      ST_RF_FB:   state_d = ST_RF_PAL;
      ST_RF_PAL:  state_d = ST_RF_ACC;
      ST_RF_ACC:  state_d = k_last ? ST_RF_PUSH : ST_RF_FB;
      ST_RF_PUSH: begin
        if (can_push) state_d = g_last ? ST_IDLE : ST_RF_FB;
      end
      ST_PUSH: begin
        if (can_push) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    fb_we_o       = 1'b0;
    fb_waddr_o    = FbAw'(lin_q >> 1);
    fb_wdata_o    = lin_q[0] ? {ci_q, fb_rdata_i[3:0]} : {fb_rdata_i[7:4], ci_q};
    fb_raddr_o    = FbAw'(lin_q >> 1);
    dirty_we_o    = 1'b0;
    dirty_waddr_o = RowAw'(y_q);
    dirty_wdata_o = 1'b1;
    dirty_raddr_o = RowAw'(y_q);
    pal_we_o      = 1'b0;
    pal_waddr_o   = pal_slot_q;
    pal_wdata_o   = pal_col_q;
    pal_raddr_o   = nibble;
    load_plain    = 1'b0;
    load_group    = 1'b0;
    case (state_q)
      ST_INIT: begin
        dirty_we_o    = (sw_q < SwW'(HEIGHT));
        dirty_waddr_o = RowAw'(sw_q);
        dirty_wdata_o = 1'b0;
        pal_we_o      = (sw_q < SwW'(PAL_DEPTH));
        pal_waddr_o   = IDX_W'(sw_q);
        pal_wdata_o   = '0;
      end
      ST_SP_WR: begin
        fb_we_o    = 1'b1;
        dirty_we_o = 1'b1;
      end
      ST_FILL: begin
        fb_we_o       = 1'b1;
        fb_waddr_o    = FbAw'(sw_q);
        fb_wdata_o    = fill_byte_q;
        dirty_we_o    = (sw_q < SwW'(HEIGHT));
        dirty_waddr_o = RowAw'(sw_q);
      end
      ST_PAL: begin
        pal_we_o      = (sw_q == '0);
        dirty_we_o    = 1'b1;
        dirty_waddr_o = RowAw'(sw_q);
      end
      ST_RF_DCHK: begin
        dirty_we_o    = dirty_rdata_i;
        dirty_wdata_o = 1'b0;
      end
      ST_RF_PUSH: load_group = can_push;
      ST_PUSH:    load_plain = can_push;
      default: ;
    endcase
  end

  always_comb begin
    y_d         = y_q;
    lin_d       = lin_q;
    ci_d        = ci_q;
    fill_byte_d = fill_byte_q;
    pal_slot_d  = pal_slot_q;
    pal_col_d   = pal_col_q;
    res_row_d   = res_row_q;
    pv_d        = pv_q;
    sw_d        = sw_q;
    g_d         = g_q;
    k_d         = k_q;
    px_d        = px_q;
    px_ok_d     = px_ok_q;
    pix_d       = pix_q;
    if (accept) begin
      y_d         = y_coord_i;
      lin_d       = LinW'(LinW'(y_coord_i) * LinW'(WIDTH))
                    + ((cmd == CMD_REFRESH) ? '0 : LinW'(x_coord_i));
      ci_d        = colour_index_i;
      fill_byte_d = (cmd == CMD_FILL) ? {colour_index_i, colour_index_i} : '0;
      pal_slot_d  = palette_slot_i;
      pal_col_d   = palette_colour_i;
      res_row_d   = (cmd == CMD_REFRESH) ? y_coord_i : '0;
      pv_d        = '0;
    end
    case (state_q)
      ST_INIT:   sw_d = init_done ? '0 : sw_q + 1'b1;
      ST_FILL:   sw_d = fill_done ? '0 : sw_q + 1'b1;
      ST_PAL:    sw_d = pal_done ? '0 : sw_q + 1'b1;
      ST_GP_DAT: pv_d = nibble;
      ST_RF_DCHK: begin
        g_d   = '0;
        k_d   = '0;
        px_d  = '0;
        pix_d = '0;
      end
      ST_RF_FB:  px_ok_d = (px_q < PxW'(WIDTH));
      ST_RF_ACC: begin
        for (int s = 0; s < MAX_LANES; s++) begin
          if ((s < PIXELS_PER_RESULT) && (s == int'(k_q))) begin
            pix_d[COLOR_W*s +: COLOR_W] = px_ok_q ? pal_rdata_i : '0;
          end
        end
        k_d   = k_last ? '0 : k_q + 1'b1;
        px_d  = px_q + 1'b1;
        lin_d = lin_q + 1'b1;
      end
      ST_RF_PUSH: begin
        if (can_push && !g_last) begin
          g_d   = g_q + 1'b1;
          pix_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_pv_d    = out_pv_q;
    out_sent_d  = out_sent_q;
    out_row_d   = out_row_q;
    out_grp_d   = out_grp_q;
    out_pix_d   = out_pix_q;
    out_last_d  = out_last_q;
    if (load_plain) begin
      out_valid_d = 1'b1;
      out_pv_d    = pv_q;
      out_sent_d  = 1'b0;
      out_row_d   = res_row_q;
      out_grp_d   = '0;
      out_pix_d   = '0;
      out_last_d  = 1'b1;
    end else if (load_group) begin
      out_valid_d = 1'b1;
      out_pv_d    = '0;
      out_sent_d  = 1'b1;
      out_row_d   = y_q;
      out_grp_d   = GROUP_W'(g_q);
      out_pix_d   = pix_q;
      out_last_d  = g_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sw_q        <= sw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q         <= y_d;
    lin_q       <= lin_d;
    ci_q        <= ci_d;
    fill_byte_q <= fill_byte_d;
    pal_slot_q  <= pal_slot_d;
    pal_col_q   <= pal_col_d;
    res_row_q   <= res_row_d;
    pv_q        <= pv_d;
    g_q         <= g_d;
    k_q         <= k_d;
    px_q        <= px_d;
    px_ok_q     <= px_ok_d;
    pix_q       <= pix_d;
    out_pv_q    <= out_pv_d;
    out_sent_q  <= out_sent_d;
    out_row_q   <= out_row_d;
    out_grp_q   <= out_grp_d;
    out_pix_q   <= out_pix_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = out_pv_q;
  assign row_sent_o    = out_sent_q;
  assign row_number_o  = out_row_q;
  assign group_index_o = out_grp_q;
  assign pixel_group_o = out_pix_q;
  assign last_o        = out_last_q;

endmodule
`default_nettype wire

// ----- rtl/core/packed_frame_buffer_refresh_core.sv -----
// Top level of the packed frame buffer refresh core: memories and command sequencer.
//
// Commands enter on the input channel (in_valid_i / in_stall_o) and results leave on the
// output channel (out_valid_o / out_stall_i); a transaction completes when valid is high
// and stall is low. The core works on one command at a time. Set pixel reads the byte,
// then merges and writes it back before its result is loaded; get pixel reads the byte
// and then takes its nibble. Palette write sweeps the row dirty bits; fill and clear
// sweep the frame store one byte per cycle and mark rows dirty on the same pass.
// Refresh of a dirty row reads and clears the row's dirty bit, then takes each pixel
// position through the frame store read, the palette memory read and the accumulate
// step, and pushes one result for every PIXELS_PER_RESULT pixels, which gives
// ceil(WIDTH / PIXELS_PER_RESULT) results. A clean row gives one result once its dirty
// bit is read; an out-of-range row, an out-of-range pixel or an unknown command goes
// straight to its result. A single result register sits on the output, so the next
// command is accepted while the last result still waits. When the receiver stalls, the
// core holds its next result and pauses until the register frees. After reset the core
// clears the dirty bits and the palette with in_stall_o high, but not the frame store.
`timescale 1ns / 1ps
`default_nettype none
module packed_frame_buffer_refresh_core #(
  parameter int unsigned WIDTH             = pfb_pkg::WIDTH_DEF,
  parameter int unsigned HEIGHT            = pfb_pkg::HEIGHT_DEF,
  parameter int unsigned PIXELS_PER_RESULT = pfb_pkg::PPR_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [pfb_pkg::CMD_W-1:0]    command_i,
  input  wire logic [pfb_pkg::COORD_W-1:0]  x_coord_i,
  input  wire logic [pfb_pkg::COORD_W-1:0]  y_coord_i,
  input  wire logic [pfb_pkg::IDX_W-1:0]    colour_index_i,
  input  wire logic [pfb_pkg::IDX_W-1:0]    palette_slot_i,
  input  wire logic [pfb_pkg::COLOR_W-1:0]  palette_colour_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [pfb_pkg::IDX_W-1:0]    pixel_value_o,
  output logic                              row_sent_o,
  output logic      [pfb_pkg::COORD_W-1:0]  row_number_o,
  output logic      [pfb_pkg::GROUP_W-1:0]  group_index_o,
  output logic      [pfb_pkg::PIXGRP_W-1:0] pixel_group_o,
  output logic                              last_o
);

  import pfb_pkg::*;

  localparam int unsigned StoreBytes = (WIDTH * HEIGHT + 1) / 2;
  localparam int unsigned FbAw       = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;
  localparam int unsigned RowAw      = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;

  logic                fb_we;
  logic [FbAw-1:0]     fb_waddr, fb_raddr;
  logic [BYTE_W-1:0]   fb_wdata, fb_rdata;
  logic                dirty_we, dirty_wdata, dirty_rdata;
  logic [RowAw-1:0]    dirty_waddr, dirty_raddr;
  logic                pal_we;
  logic [IDX_W-1:0]    pal_waddr, pal_raddr;
  logic [COLOR_W-1:0]  pal_wdata, pal_rdata;

  pfb_ram #(
    .DATA_W (BYTE_W),
    .DEPTH  (StoreBytes)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fb_we),
    .waddr_i (fb_waddr),
    .wdata_i (fb_wdata),
    .raddr_i (fb_raddr),
    .rdata_o (fb_rdata)
  );

  pfb_ram #(
    .DATA_W (1),
    .DEPTH  (HEIGHT)
  ) u_dirty_ram (
    .clk_i   (clk_i),
    .we_i    (dirty_we),
    .waddr_i (dirty_waddr),
    .wdata_i (dirty_wdata),
    .raddr_i (dirty_raddr),
    .rdata_o (dirty_rdata)
  );

  pfb_ram #(
    .DATA_W (COLOR_W),
    .DEPTH  (PAL_DEPTH)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (pal_wdata),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  pfb_seq #(
    .WIDTH             (WIDTH),
    .HEIGHT            (HEIGHT),
    .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .x_coord_i        (x_coord_i),
    .y_coord_i        (y_coord_i),
    .colour_index_i   (colour_index_i),
    .palette_slot_i   (palette_slot_i),
    .palette_colour_i (palette_colour_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pixel_value_o    (pixel_value_o),
    .row_sent_o       (row_sent_o),
    .row_number_o     (row_number_o),
    .group_index_o    (group_index_o),
    .pixel_group_o    (pixel_group_o),
    .last_o           (last_o),
    .fb_we_o          (fb_we),
    .fb_waddr_o       (fb_waddr),
    .fb_wdata_o       (fb_wdata),
    .fb_raddr_o       (fb_raddr),
    .fb_rdata_i       (fb_rdata),
    .dirty_we_o       (dirty_we),
    .dirty_waddr_o    (dirty_waddr),
    .dirty_wdata_o    (dirty_wdata),
    .dirty_raddr_o    (dirty_raddr),
    .dirty_rdata_i    (dirty_rdata),
    .pal_we_o         (pal_we),
    .pal_waddr_o      (pal_waddr),
    .pal_wdata_o      (pal_wdata),
    .pal_raddr_o      (pal_raddr),
    .pal_rdata_i      (pal_rdata)
  );

endmodule
`default_nettype wire
